>>> rtl/core/dcfa_pkg.sv
package dcfa_pkg;

   localparam int VALUE_BITS = 32;
   localparam int ULEB_BITS  = (VALUE_BITS > 32) ? 32 : ((VALUE_BITS < 1) ? 1 : VALUE_BITS);
   localparam logic [31:0] ULEB_MASK = 32'((64'd1 << ULEB_BITS) - 64'd1);

   localparam logic [2:0] KIND_ADVANCE_LOC      = 3'd0;
   localparam logic [2:0] KIND_OFFSET           = 3'd1;
   localparam logic [2:0] KIND_RESTORE          = 3'd2;
   localparam logic [2:0] KIND_DEF_CFA          = 3'd3;
   localparam logic [2:0] KIND_DEF_CFA_REGISTER = 3'd4;
   localparam logic [2:0] KIND_DEF_CFA_OFFSET   = 3'd5;

   localparam logic [7:0] OP_ADVANCE_LOC1     = 8'h02;
   localparam logic [7:0] OP_ADVANCE_LOC2     = 8'h03;
   localparam logic [7:0] OP_ADVANCE_LOC4     = 8'h04;
   localparam logic [7:0] OP_DEF_CFA          = 8'h0C;
   localparam logic [7:0] OP_DEF_CFA_REGISTER = 8'h0D;
   localparam logic [7:0] OP_DEF_CFA_OFFSET   = 8'h0E;
   localparam logic [1:0] OP_HI_ADVANCE_LOC   = 2'b01;
   localparam logic [1:0] OP_HI_OFFSET        = 2'b10;
   localparam logic [1:0] OP_HI_RESTORE       = 2'b11;

   localparam logic [31:0] SHORT_DELTA_MAX = 32'h0000_003F;
   localparam logic [31:0] BYTE_DELTA_MAX  = 32'h0000_00FF;
   localparam logic [31:0] HALF_DELTA_MAX  = 32'h0000_FFFF;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         register_number;
      logic signed [31:0] frame_offset;
      logic [31:0]        address_delta;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       bad_kind;
   } rsp_type;

endpackage

>>> rtl/core/dwarf_cfa_instruction_encoder.sv
// Encodes one call-frame instruction per request word into its DWARF byte
// stream, one byte per response word, with last_byte set on the final byte.
// The block takes a request only while its sequencer is idle: after the
// accept it sends the opcode byte from ST_OPC and then each operand byte from
// ST_ARG, and the response side can stall any byte with rsp_stall. A shared
// 32-bit adder forms the scaled offset operand, and a shift register feeds
// out the ULEB128 or little-endian operand bytes. An advance of zero
// produces no response word; unsupported kinds produce a single word with
// bad_kind set and a zero byte.
module dwarf_cfa_instruction_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dcfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dcfa_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_OPC  = 3'b010,
      ST_ARG  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         reg_ff, reg_in;
   logic [31:0]        off_ff, off_in;
   logic [31:0]        delta_ff, delta_in;
   logic [31:0]        adj_ff, adj_in;
   logic [31:0]        val_ff, val_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               le_ff, le_in;
   logic               more_ff, more_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dcfa_pkg::rsp_type  rsp_ff, rsp_in;

   logic [31:0]        add_a;
   logic [31:0]        add_b;
   logic [31:0]        sum;
   logic [31:0]        rem;
   logic               slot_free;
   logic               emit;
   dcfa_pkg::rsp_type  emit_word;

   assign sum       = add_a + add_b;
   assign rem       = val_ff >> 7;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      add_a = req_data.frame_offset;
      add_b = req_data.frame_offset[31] ? 32'd3 : 32'd0;
      if (state_ff == ST_OPC) begin
         add_a = ~adj_ff;
         add_b = 32'd1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      reg_in    = reg_ff;
      off_in    = off_ff;
      delta_in  = delta_ff;
      adj_in    = adj_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      le_in     = le_ff;
      more_in   = more_ff;
      emit      = 1'b0;
      emit_word = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               reg_in   = req_data.register_number;
               off_in   = req_data.frame_offset;
               delta_in = req_data.address_delta;
               adj_in   = 32'($signed(sum) >>> 2);
               if (!(req_data.kind == dcfa_pkg::KIND_ADVANCE_LOC &&
                     req_data.address_delta == '0)) begin
                  state_in = ST_OPC;
               end
            end
         end
         ST_OPC: begin
            if (slot_free) begin
               emit     = 1'b1;
               le_in    = 1'b0;
               more_in  = 1'b0;
               cnt_in   = 3'd1;
               state_in = ST_ARG;
               case (kind_ff)
                  dcfa_pkg::KIND_ADVANCE_LOC: begin
                     le_in  = 1'b1;
                     val_in = delta_ff;
                     if (delta_ff <= dcfa_pkg::SHORT_DELTA_MAX) begin
                        emit_word.out_byte  = {dcfa_pkg::OP_HI_ADVANCE_LOC, delta_ff[5:0]};
                        emit_word.last_byte = 1'b1;
                        state_in            = ST_IDLE;
                     end else if (delta_ff <= dcfa_pkg::BYTE_DELTA_MAX) begin
                        emit_word.out_byte = dcfa_pkg::OP_ADVANCE_LOC1;
                     end else if (delta_ff <= dcfa_pkg::HALF_DELTA_MAX) begin
                        emit_word.out_byte = dcfa_pkg::OP_ADVANCE_LOC2;
                        cnt_in             = 3'd2;
                     end else begin
                        emit_word.out_byte = dcfa_pkg::OP_ADVANCE_LOC4;
                        cnt_in             = 3'd4;
                     end
                  end
                  dcfa_pkg::KIND_OFFSET: begin
                     emit_word.out_byte = {dcfa_pkg::OP_HI_OFFSET, 6'd0} + reg_ff;
                     val_in             = sum & dcfa_pkg::ULEB_MASK;
                  end
                  dcfa_pkg::KIND_RESTORE: begin
                     emit_word.out_byte  = {dcfa_pkg::OP_HI_RESTORE, 6'd0} + reg_ff;
                     emit_word.last_byte = 1'b1;
                     state_in            = ST_IDLE;
                  end
                  dcfa_pkg::KIND_DEF_CFA: begin
                     emit_word.out_byte = dcfa_pkg::OP_DEF_CFA;
                     val_in             = {24'd0, reg_ff} & dcfa_pkg::ULEB_MASK;
                     more_in            = 1'b1;
                  end
                  dcfa_pkg::KIND_DEF_CFA_REGISTER: begin
                     emit_word.out_byte = dcfa_pkg::OP_DEF_CFA_REGISTER;
                     val_in             = {24'd0, reg_ff} & dcfa_pkg::ULEB_MASK;
                  end
                  dcfa_pkg::KIND_DEF_CFA_OFFSET: begin
                     emit_word.out_byte = dcfa_pkg::OP_DEF_CFA_OFFSET;
                     val_in             = off_ff & dcfa_pkg::ULEB_MASK;
                  end
                  default: begin
                     emit_word.last_byte = 1'b1;
                     emit_word.bad_kind  = 1'b1;
                     state_in            = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ARG: begin
            if (slot_free) begin
               emit = 1'b1;
               if (le_ff) begin
                  emit_word.out_byte = val_ff[7:0];
                  val_in             = val_ff >> 8;
                  cnt_in             = cnt_ff - 3'd1;
                  if (cnt_ff == 3'd1) begin
                     emit_word.last_byte = 1'b1;
                     state_in            = ST_IDLE;
                  end
               end else begin
                  emit_word.out_byte = {(rem != '0), val_ff[6:0]};
                  val_in             = rem;
                  if (rem == '0) begin
                     if (more_ff) begin
                        more_in = 1'b0;
                        val_in  = off_ff & dcfa_pkg::ULEB_MASK;
                     end else begin
                        emit_word.last_byte = 1'b1;
                        state_in            = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      reg_ff   <= reg_in;
      off_ff   <= off_in;
      delta_ff <= delta_in;
      adj_ff   <= adj_in;
      val_ff   <= val_in;
      cnt_ff   <= cnt_in;
      le_ff    <= le_in;
      more_ff  <= more_in;
      rsp_ff   <= rsp_in;
   end

endmodule
